// File: rtl/core/vfc_pkg.sv
// Shared types, constants and address helpers for the voxel face culler.
package vfc_pkg;

   localparam int CHUNK_SIDE = 16;
   localparam int BLOCK_BITS = 8;
   localparam int CHUNK_BITS = $clog2(CHUNK_SIDE);

   localparam int COORD_W    = 4;
   localparam int DIR_W      = 3;
   localparam int SIDE_W     = 2;
   localparam int ID_W       = 8;
   localparam int INDEX_W    = 17;
   localparam int PRESENT_W  = 4;

   localparam int VOX_AW     = 3 * CHUNK_BITS;
   localparam int NB_AW      = SIDE_W + 2 * CHUNK_BITS;

   localparam logic [INDEX_W-1:0] VERTS_PER_FACE = INDEX_W'(4);

   typedef enum logic [1:0] {
      CMD_CLEAR     = 2'd0,
      CMD_WRITE_VOX = 2'd1,
      CMD_WRITE_NB  = 2'd2,
      CMD_MESH      = 2'd3
   } cmd_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_POS_X = 3'd0,
      DIR_NEG_X = 3'd1,
      DIR_POS_Y = 3'd2,
      DIR_NEG_Y = 3'd3,
      DIR_POS_Z = 3'd4,
      DIR_NEG_Z = 3'd5
   } dir_type;

   typedef enum logic [SIDE_W-1:0] {
      SIDE_WEST  = 2'd0,
      SIDE_EAST  = 2'd1,
      SIDE_NORTH = 2'd2,
      SIDE_SOUTH = 2'd3
   } side_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OWN,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [DIR_W-1:0]   dir;
      logic [ID_W-1:0]    block;
      logic [INDEX_W-1:0] base;
      logic               last;
   } face_type;

   function automatic logic coord_ok(input logic [COORD_W-1:0] c);
      return int'(c) < CHUNK_SIDE;
   endfunction

   function automatic logic coord_below_top(input logic [COORD_W-1:0] c);
      return int'(c) < CHUNK_SIDE - 1;
   endfunction

   function automatic logic [VOX_AW-1:0] vox_addr_f(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
      return {CHUNK_BITS'(x), CHUNK_BITS'(z), CHUNK_BITS'(y)};
   endfunction

   function automatic logic [NB_AW-1:0] nb_addr_f(input logic [SIDE_W-1:0]  side,
                                                  input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] y);
      return {side, CHUNK_BITS'(a), CHUNK_BITS'(y)};
   endfunction

endpackage

// File: rtl/core/vfc_ram.sv
// Single-port synchronous RAM with registered read data.
module vfc_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/vfc_ctrl.sv
// Command sequencer: memory writes, neighbour scan and face generation.
module vfc_ctrl
   import vfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COORD_W-1:0]    req_pos_z,
   input  logic [ID_W-1:0]       req_block_id,
   input  logic [SIDE_W-1:0]     req_side,
   input  logic [PRESENT_W-1:0]  present,
   output logic                  vox_we,
   output logic [VOX_AW-1:0]     vox_addr,
   output logic [BLOCK_BITS-1:0] vox_wdata,
   input  logic [BLOCK_BITS-1:0] vox_rdata,
   output logic                  nb_we,
   output logic [NB_AW-1:0]      nb_addr,
   output logic                  nb_wdata,
   input  logic                  nb_rdata,
   output logic                  face_valid,
   output face_type              face
);

   state_type               state_ff, state_in;
   logic [COORD_W-1:0]      x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [BLOCK_BITS-1:0]   own_ff, own_in;
   logic [DIR_W-1:0]        chk_ff, chk_in;
   logic [INDEX_W-1:0]      count_ff, count_in;
   logic                    pend_valid_ff, pend_valid_in;
   face_type                pend_ff, pend_in;

   logic                    accept;
   logic                    req_ok;
   logic [DIR_W-1:0]        issue_dir;
   logic [COORD_W-1:0]      nx, ny, nz, plane_a;
   side_type                plane_side;
   logic [COORD_W-1:0]      req_a;
   logic                    interior, boundary_hit, exposed;
   face_type                new_face;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign req_ok = coord_ok(req_pos_x) && coord_ok(req_pos_y) && coord_ok(req_pos_z);
   assign req_a  = (req_side == SIDE_WEST || req_side == SIDE_EAST) ? req_pos_z : req_pos_x;

   // neighbour address for the direction being issued
   assign issue_dir = (state_ff == ST_OWN) ? DIR_POS_X : DIR_W'(chk_ff + 3'd1);

   always_comb begin
      nx         = x_ff;
      ny         = y_ff;
      nz         = z_ff;
      plane_side = SIDE_WEST;
      plane_a    = z_ff;
      case (issue_dir)
         DIR_POS_X: begin
            nx         = COORD_W'(x_ff + 4'd1);
            plane_side = SIDE_WEST;
            plane_a    = z_ff;
         end
         DIR_NEG_X: begin
            nx         = COORD_W'(x_ff - 4'd1);
            plane_side = SIDE_EAST;
            plane_a    = z_ff;
         end
         DIR_POS_Y: ny = COORD_W'(y_ff + 4'd1);
         DIR_NEG_Y: ny = COORD_W'(y_ff - 4'd1);
         DIR_POS_Z: begin
            nz         = COORD_W'(z_ff + 4'd1);
            plane_side = SIDE_NORTH;
            plane_a    = x_ff;
         end
         DIR_NEG_Z: begin
            nz         = COORD_W'(z_ff - 4'd1);
            plane_side = SIDE_SOUTH;
            plane_a    = x_ff;
         end
         default: begin
            nx = x_ff;
         end
      endcase
   end

   // exposure of the direction whose reads return this cycle
   always_comb begin
      interior     = 1'b0;
      boundary_hit = 1'b1;
      case (chk_ff)
         DIR_POS_X: begin
            interior     = coord_below_top(x_ff);
            boundary_hit = present[0] && !nb_rdata;
         end
         DIR_NEG_X: begin
            interior     = (x_ff != '0);
            boundary_hit = present[1] && !nb_rdata;
         end
         DIR_POS_Y: interior = coord_below_top(y_ff);
         DIR_NEG_Y: interior = (y_ff != '0);
         DIR_POS_Z: begin
            interior     = coord_below_top(z_ff);
            boundary_hit = present[2] && !nb_rdata;
         end
         default: begin
            interior     = (z_ff != '0);
            boundary_hit = present[3] && !nb_rdata;
         end
      endcase
      exposed = interior ? (vox_rdata == '0) : boundary_hit;
   end

   always_comb begin
      new_face.x     = x_ff;
      new_face.y     = y_ff;
      new_face.z     = z_ff;
      new_face.dir   = chk_ff;
      new_face.block = ID_W'(own_ff);
      new_face.base  = count_ff;
      new_face.last  = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == CMD_MESH && req_ok) begin
               state_in = ST_OWN;
            end
         end
         ST_OWN:   state_in = (vox_rdata == '0) ? ST_IDLE : ST_SCAN;
         ST_SCAN:  state_in = (chk_ff == DIR_NEG_Z) ? ST_FLUSH : ST_SCAN;
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      vox_we     = 1'b0;
      nb_we      = 1'b0;
      vox_addr   = vox_addr_f(nx, ny, nz);
      nb_addr    = nb_addr_f(plane_side, plane_a, y_ff);
      vox_wdata  = BLOCK_BITS'(req_block_id);
      nb_wdata   = (req_block_id != '0);
      face_valid = 1'b0;
      face       = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            vox_addr = vox_addr_f(req_pos_x, req_pos_y, req_pos_z);
            nb_addr  = nb_addr_f(req_side, req_a, req_pos_y);
            vox_we   = accept && req_cmd == CMD_WRITE_VOX && req_ok;
            nb_we    = accept && req_cmd == CMD_WRITE_NB && req_ok;
         end
         ST_OWN: begin
            face_valid = 1'b0;
         end
         ST_SCAN: begin
            face_valid = exposed && pend_valid_ff;
         end
         ST_FLUSH: begin
            face_valid = pend_valid_ff;
            face.last  = 1'b1;
         end
         default: begin
            face_valid = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      own_in        = own_ff;
      chk_in        = chk_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in          = req_pos_x;
               y_in          = req_pos_y;
               z_in          = req_pos_z;
               pend_valid_in = 1'b0;
               if (req_cmd == CMD_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_OWN: begin
            own_in = vox_rdata;
            chk_in = DIR_POS_X;
         end
         ST_SCAN: begin
            chk_in = DIR_W'(chk_ff + 3'd1);
            if (exposed) begin
               pend_in       = new_face;
               pend_valid_in = 1'b1;
               count_in      = INDEX_W'(count_ff + VERTS_PER_FACE);
            end
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      own_ff  <= own_in;
      chk_ff  <= chk_in;
      pend_ff <= pend_in;
   end

endmodule

// File: rtl/core/voxel_face_culler_unit.sv
// Top level of the voxel face culler: memories, config register, result register.
//
//   channel   ports                          handshake
//   request   req_cmd/pos_*/block_id/side    taken when start && !busy
//   response  rsp_face_*, rsp_last ...       each face marked by rsp_strobe
//   config    csr_wdata                      written when csr_we
//
// Clear and write items are done in the accept cycle; a mesh item on air ends after the own read.
// A mesh item on a solid voxel runs the own read, six neighbour reads
// through the single voxel RAM port, and a flush step to hand out the final face.
// A face waits until the next face or the final cycle, then is registered out.
// Reset clears the vertex counter and the config register; RAM contents are
// left as they are. The receiver cannot stall.
module voxel_face_culler_unit
   import vfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_cmd,
   input  logic [COORD_W-1:0]   req_pos_x,
   input  logic [COORD_W-1:0]   req_pos_y,
   input  logic [COORD_W-1:0]   req_pos_z,
   input  logic [ID_W-1:0]      req_block_id,
   input  logic [SIDE_W-1:0]    req_side,
   output logic                 rsp_strobe,
   output logic [COORD_W-1:0]   rsp_face_x,
   output logic [COORD_W-1:0]   rsp_face_y,
   output logic [COORD_W-1:0]   rsp_face_z,
   output logic [DIR_W-1:0]     rsp_face_dir,
   output logic [ID_W-1:0]      rsp_face_block,
   output logic [INDEX_W-1:0]   rsp_base_index,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic [PRESENT_W-1:0] csr_wdata
);

   logic [PRESENT_W-1:0]  present_ff;
   logic                  strobe_ff;
   face_type              rsp_ff;

   logic                  vox_we;
   logic [VOX_AW-1:0]     vox_addr;
   logic [BLOCK_BITS-1:0] vox_wdata, vox_rdata;
   logic                  nb_we;
   logic [NB_AW-1:0]      nb_addr;
   logic                  nb_wdata, nb_rdata;
   logic                  face_valid;
   face_type              face;

   vfc_ram #(
      .DATA_W (BLOCK_BITS),
      .ADDR_W (VOX_AW)
   ) u_vox_ram (
      .clock (clock),
      .we    (vox_we),
      .addr  (vox_addr),
      .wdata (vox_wdata),
      .rdata (vox_rdata)
   );

   vfc_ram #(
      .DATA_W (1),
      .ADDR_W (NB_AW)
   ) u_nb_ram (
      .clock (clock),
      .we    (nb_we),
      .addr  (nb_addr),
      .wdata (nb_wdata),
      .rdata (nb_rdata)
   );

   vfc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .req_block_id (req_block_id),
      .req_side     (req_side),
      .present      (present_ff),
      .vox_we       (vox_we),
      .vox_addr     (vox_addr),
      .vox_wdata    (vox_wdata),
      .vox_rdata    (vox_rdata),
      .nb_we        (nb_we),
      .nb_addr      (nb_addr),
      .nb_wdata     (nb_wdata),
      .nb_rdata     (nb_rdata),
      .face_valid   (face_valid),
      .face         (face)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            present_ff <= csr_wdata;
         end
         strobe_ff <= face_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (face_valid) begin
         rsp_ff <= face;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_face_x     = rsp_ff.x;
   assign rsp_face_y     = rsp_ff.y;
   assign rsp_face_z     = rsp_ff.z;
   assign rsp_face_dir   = rsp_ff.dir;
   assign rsp_face_block = rsp_ff.block;
   assign rsp_base_index = rsp_ff.base;
   assign rsp_last       = rsp_ff.last;

endmodule

// File: verif/voxel_face_culler_unit_tb.sv
// Self-checking testbench for voxel_face_culler_unit: directed table, then random items.
module voxel_face_culler_unit_tb
   import vfc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOP = CHUNK_SIDE - 1;

   typedef struct packed {
      logic                 is_cfg;
      logic [PRESENT_W-1:0] cfg_val;
      cmd_type              cmd;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [COORD_W-1:0]   z;
      logic [ID_W-1:0]      blk;
      side_type             side;
      logic                 typed;
      logic [5:0]           mask;
      logic [INDEX_W-1:0]   base0;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_cmd = '0;
   logic [COORD_W-1:0]   req_pos_x = '0;
   logic [COORD_W-1:0]   req_pos_y = '0;
   logic [COORD_W-1:0]   req_pos_z = '0;
   logic [ID_W-1:0]      req_block_id = '0;
   logic [SIDE_W-1:0]    req_side = '0;
   logic                 rsp_strobe;
   logic [COORD_W-1:0]   rsp_face_x;
   logic [COORD_W-1:0]   rsp_face_y;
   logic [COORD_W-1:0]   rsp_face_z;
   logic [DIR_W-1:0]     rsp_face_dir;
   logic [ID_W-1:0]      rsp_face_block;
   logic [INDEX_W-1:0]   rsp_base_index;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [PRESENT_W-1:0] csr_wdata = '0;

   // predictor state, indexed [x][y][z] and [side][a][y]
   logic [ID_W-1:0]      chunk_m [CHUNK_SIDE][CHUNK_SIDE][CHUNK_SIDE];
   bit                   chunk_known [CHUNK_SIDE][CHUNK_SIDE][CHUNK_SIDE];
   bit                   plane_m [4][CHUNK_SIDE][CHUNK_SIDE];
   bit                   plane_known [4][CHUNK_SIDE][CHUNK_SIDE];
   logic [INDEX_W-1:0]   vert_count;
   logic [PRESENT_W-1:0] present_m;

   face_type             hits [6];
   int                   hit_count;
   face_type             faces_due [$];
   step_type             script [$];
   int                   errors = 0;
   int                   items_sent = 0;
   int                   burst_left = 1;

   voxel_face_culler_unit dut (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_pos_x, .req_pos_y, .req_pos_z, .req_block_id, .req_side,
      .rsp_strobe, .rsp_face_x, .rsp_face_y, .rsp_face_z, .rsp_face_dir,
      .rsp_face_block, .rsp_base_index, .rsp_last,
      .csr_we, .csr_wdata
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic bit face_open(input int d, input logic [COORD_W-1:0] x, y, z);
      case (d)
         DIR_POS_X: return (x < TOP) ? chunk_m[x+1][y][z] == '0
                                     : present_m[SIDE_WEST] && !plane_m[SIDE_WEST][z][y];
         DIR_NEG_X: return (x > 0) ? chunk_m[x-1][y][z] == '0
                                   : present_m[SIDE_EAST] && !plane_m[SIDE_EAST][z][y];
         DIR_POS_Y: return (y < TOP) ? chunk_m[x][y+1][z] == '0 : 1'b1;
         DIR_NEG_Y: return (y > 0) ? chunk_m[x][y-1][z] == '0 : 1'b1;
         DIR_POS_Z: return (z < TOP) ? chunk_m[x][y][z+1] == '0
                                     : present_m[SIDE_NORTH] && !plane_m[SIDE_NORTH][x][y];
         default:   return (z > 0) ? chunk_m[x][y][z-1] == '0
                                   : present_m[SIDE_SOUTH] && !plane_m[SIDE_SOUTH][x][y];
      endcase
   endfunction

   function automatic void build_faces(input logic [COORD_W-1:0] x, y, z,
                                       input logic [ID_W-1:0] blk, input logic [5:0] mask,
                                       input logic [INDEX_W-1:0] base0);
      int total;
      total = $countones(mask);
      hit_count = 0;
      for (int d = DIR_POS_X; d <= DIR_NEG_Z; d++) begin
         if (mask[d]) begin
            hits[hit_count] = {x, y, z, DIR_W'(d), blk,
                               INDEX_W'(base0 + VERTS_PER_FACE * hit_count),
                               hit_count == total - 1};
            hit_count++;
         end
      end
   endfunction

   function automatic void cull_voxel_item(input cmd_type c, input logic [COORD_W-1:0] x, y, z,
                                           input logic [ID_W-1:0] b, input side_type s);
      logic [ID_W-1:0] own;
      logic [5:0]      open;
      hit_count = 0;
      case (c)
         CMD_CLEAR: vert_count = '0;
         CMD_WRITE_VOX: begin
            chunk_m[x][y][z] = b;
            chunk_known[x][y][z] = 1'b1;
         end
         CMD_WRITE_NB: begin
            if (s == SIDE_WEST || s == SIDE_EAST) begin
               plane_m[s][z][y] = b != '0;
               plane_known[s][z][y] = 1'b1;
            end else begin
               plane_m[s][x][y] = b != '0;
               plane_known[s][x][y] = 1'b1;
            end
         end
         default: begin
            own = chunk_m[x][y][z];
            open = '0;
            if (own != '0)
               for (int d = DIR_POS_X; d <= DIR_NEG_Z; d++) open[d] = face_open(d, x, y, z);
            build_faces(x, y, z, own, open, vert_count);
            vert_count = vert_count + INDEX_W'(VERTS_PER_FACE * hit_count);
         end
      endcase
   endfunction

   task automatic send_item(input cmd_type c, input logic [COORD_W-1:0] x, y, z,
                            input logic [ID_W-1:0] b, input side_type s, input logic typed,
                            input logic [5:0] mask, input logic [INDEX_W-1:0] base0);
      int gap;
      req_cmd <= c;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_block_id <= b;
      req_side <= s;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      cull_voxel_item(c, x, y, z, b, s);
      if (typed) build_faces(x, y, z, b, mask, base0);
      for (int i = 0; i < hit_count; i++) faces_due.push_back(hits[i]);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (faces_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic set_present(input logic [PRESENT_W-1:0] v);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      present_m = v;
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return COORD_W'(TOP);
         2: return COORD_W'($urandom_range(0, 2));
         3: return COORD_W'($urandom_range(TOP - 2, TOP));
         default: return COORD_W'($urandom_range(0, TOP));
      endcase
   endfunction

   function automatic logic [ID_W-1:0] rand_block();
      case ($urandom_range(0, 4))
         0, 1: return '0;
         2: return '1;
         default: return ID_W'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic side_type rand_side();
      return side_type'($urandom_range(0, 3));
   endfunction

   task automatic touch_voxel(input logic [COORD_W-1:0] x, y, z);
      if (!chunk_known[x][y][z])
         send_item(CMD_WRITE_VOX, x, y, z, rand_block(), rand_side(), 1'b0, '0, '0);
   endtask

   task automatic touch_plane(input side_type s, input logic [COORD_W-1:0] a, y);
      if (!plane_known[s][a][y]) begin
         if (s == SIDE_WEST || s == SIDE_EAST)
            send_item(CMD_WRITE_NB, pick_coord(), y, a, rand_block(), s, 1'b0, '0, '0);
         else
            send_item(CMD_WRITE_NB, a, y, pick_coord(), rand_block(), s, 1'b0, '0, '0);
      end
   endtask

   // a mesh reads its own cell, the in-chunk neighbours and the facing planes at the edges
   task automatic fill_around(input logic [COORD_W-1:0] x, y, z);
      touch_voxel(x, y, z);
      if (x < TOP) touch_voxel(COORD_W'(x + 1), y, z);
      if (x > 0) touch_voxel(COORD_W'(x - 1), y, z);
      if (y < TOP) touch_voxel(x, COORD_W'(y + 1), z);
      if (y > 0) touch_voxel(x, COORD_W'(y - 1), z);
      if (z < TOP) touch_voxel(x, y, COORD_W'(z + 1));
      if (z > 0) touch_voxel(x, y, COORD_W'(z - 1));
      if (x == TOP) touch_plane(SIDE_WEST, z, y);
      if (x == 0) touch_plane(SIDE_EAST, z, y);
      if (z == TOP) touch_plane(SIDE_NORTH, x, y);
      if (z == 0) touch_plane(SIDE_SOUTH, x, y);
   endtask

   function automatic void plan_step(input logic is_cfg, input logic [PRESENT_W-1:0] cv,
                                     input cmd_type c, input logic [COORD_W-1:0] x, y, z,
                                     input logic [ID_W-1:0] b, input side_type s,
                                     input logic typed, input logic [5:0] mask,
                                     input logic [INDEX_W-1:0] base0);
      script.push_back({is_cfg, cv, c, x, y, z, b, s, typed, mask, base0});
   endfunction

   always @(posedge clock) begin : rsp_check
      face_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (faces_due.size() == 0) begin
            flag_mismatch($sformatf("face with nothing expected: %0d,%0d,%0d dir %0d",
                                    rsp_face_x, rsp_face_y, rsp_face_z, rsp_face_dir));
         end else begin
            want = faces_due.pop_front();
            if (rsp_face_x !== want.x || rsp_face_y !== want.y || rsp_face_z !== want.z ||
                rsp_face_dir !== want.dir || rsp_face_block !== want.block ||
                rsp_base_index !== want.base || rsp_last !== want.last)
               flag_mismatch({
                  $sformatf("got %0d,%0d,%0d dir %0d blk %0d base %0d last %0b, ",
                            rsp_face_x, rsp_face_y, rsp_face_z, rsp_face_dir,
                            rsp_face_block, rsp_base_index, rsp_last),
                  $sformatf("want %0d,%0d,%0d dir %0d blk %0d base %0d last %0b",
                            want.x, want.y, want.z, want.dir, want.block,
                            want.base, want.last)});
         end
      end
   end

   initial begin
      step_type             st;
      int                   goal;
      logic [COORD_W-1:0]   x, y, z;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      vert_count = '0;
      present_m = '0;
      burst_left = $urandom_range(1, 12);

      // no side chunks after reset: faces only inside the chunk and at the top and bottom
      plan_step(1'b0, '0, CMD_WRITE_NB, 4'd3, 4'd0, 4'd0, 8'd0, SIDE_EAST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_NB, 4'd0, 4'd0, 4'd9, 8'd7, SIDE_SOUTH, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd0, 4'd0, 4'd0, 8'd5, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd1, 4'd0, 4'd0, 8'd0, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd0, 4'd1, 4'd0, 8'd0, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd0, 4'd0, 4'd1, 8'd0, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_MESH, 4'd0, 4'd0, 4'd0, 8'd5, SIDE_WEST, 1'b1, 6'b011101, 17'd0);
      plan_step(1'b0, '0, CMD_MESH, 4'd1, 4'd0, 4'd0, 8'd0, SIDE_NORTH, 1'b1, 6'b000000, 17'd0);
      plan_step(1'b0, '0, CMD_CLEAR, 4'd15, 4'd15, 4'd15, 8'd255, SIDE_SOUTH, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_NB, 4'd6, 4'd15, 4'd15, 8'd0, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_NB, 4'd15, 4'd15, 4'd2, 8'd255, SIDE_NORTH, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd15, 4'd15, 4'd15, 8'd255, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd14, 4'd15, 4'd15, 8'd128, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd15, 4'd14, 4'd15, 8'd0, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd15, 4'd15, 4'd14, 8'd0, SIDE_WEST, 1'b0, '0, '0);
      // all side chunks loaded
      plan_step(1'b1, 4'hF, CMD_CLEAR, '0, '0, '0, '0, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_MESH, 4'd15, 4'd15, 4'd15, 8'd255, SIDE_WEST, 1'b1, 6'b101101,
                17'd0);
      plan_step(1'b0, '0, CMD_MESH, 4'd0, 4'd0, 4'd0, 8'd5, SIDE_EAST, 1'b1, 6'b011111, 17'd16);
      plan_step(1'b0, '0, CMD_WRITE_VOX, 4'd0, 4'd0, 4'd0, 8'd0, SIDE_WEST, 1'b0, '0, '0);
      plan_step(1'b0, '0, CMD_MESH, 4'd0, 4'd0, 4'd0, 8'd0, SIDE_SOUTH, 1'b1, 6'b000000, 17'd0);
      plan_step(1'b0, '0, CMD_MESH, 4'd15, 4'd15, 4'd15, 8'd77, SIDE_NORTH, 1'b0, '0, '0);

      foreach (script[i]) begin
         st = script[i];
         if (st.is_cfg)
            set_present(st.cfg_val);
         else
            send_item(st.cmd, st.x, st.y, st.z, st.blk, st.side, st.typed, st.mask, st.base0);
      end

      for (int p = 0; p < 4; p++) begin
         case (p)
            1: set_present('0);
            2: set_present('1);
            default: set_present(PRESENT_W'($urandom_range(1, 14)));
         endcase
         goal = items_sent + 22;
         while (items_sent < goal) begin
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
            case ($urandom_range(0, 19))
               0: send_item(CMD_CLEAR, x, y, z, rand_block(), rand_side(), 1'b0, '0, '0);
               1, 2, 3, 4, 5:
                  send_item(CMD_WRITE_VOX, x, y, z, rand_block(), rand_side(), 1'b0, '0, '0);
               6, 7: send_item(CMD_WRITE_NB, x, y, z, rand_block(), rand_side(), 1'b0, '0, '0);
               default: begin
                  fill_around(x, y, z);
                  send_item(CMD_MESH, x, y, z, ID_W'($urandom_range(0, 255)), rand_side(),
                            1'b0, '0, '0);
               end
            endcase
         end
      end

      settle();
      if (faces_due.size() != 0)
         flag_mismatch($sformatf("%0d faces never arrived", faces_due.size()));
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/vfc_pkg.sv
rtl/core/vfc_ram.sv
rtl/core/vfc_ctrl.sv
rtl/core/voxel_face_culler_unit.sv
verif/voxel_face_culler_unit_tb.sv
